### design/assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked on clk, masked while rst_n is low.
`define BF3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked on clk, also checked through reset.
`define BF3_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BF3_ASSERT(lbl, prop, msg)
`define BF3_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### design/bf3_pkg.sv
// Package for the 3x3 box filter: field widths, register codes, divide constants.
`timescale 1ns / 1ps
package bf3_pkg;
  localparam int PIXEL_W      = 8;
  localparam int IMG_WIDTH_W  = 11;
  localparam int IMG_HEIGHT_W = 12;
  localparam int CFG_W        = 12;
  localparam int CFG_IDX_W    = 1;
  localparam int SUM_W        = 12;   // nine 8-bit pixels, max 2295
  localparam int MAX_WIDTH_DEF = 1024;

  localparam logic [IMG_WIDTH_W-1:0]  RESET_WIDTH  = 11'd720;
  localparam logic [IMG_HEIGHT_W-1:0] RESET_HEIGHT = 12'd960;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  // floor(s/9) == (s * 3641) >> 15 for every s below 2^15
  localparam int DIV9_MUL_W = 12;
  localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 12'd3641;
  localparam int DIV9_SHIFT = 15;

  typedef struct packed {
    logic emit;       // item completes a full 3x3 neighborhood
    logic row_end;
    logic frame_end;
  } bf3_tag_t;
endpackage

### design/bf3_stream_ifs.sv
// Valid/ready stream interfaces for input pixels and filter results.
`timescale 1ns / 1ps
interface bf3_pix_if import bf3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface bf3_mean_if import bf3_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] mean_value;
  logic               row_end;
  logic               frame_end;
  modport source (output valid, output mean_value, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input mean_value, input row_end, input frame_end,
                  output ready);
endinterface

### design/bf3_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`timescale 1ns / 1ps
module bf3_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata_r
);
  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end
endmodule

### design/bf3_pos_ctrl.sv
// Config registers, effective geometry and raster position counters.
`timescale 1ns / 1ps
module bf3_pos_ctrl import bf3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         acc,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output bf3_tag_t                     tag
);
  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WW > IMG_WIDTH_W) ? WW : IMG_WIDTH_W;
  localparam logic [EW-1:0] MAX_W_E = EW'(MAX_WIDTH);

  logic [IMG_WIDTH_W-1:0]  image_width_r;
  logic [IMG_HEIGHT_W-1:0] image_height_r;
  logic [CW-1:0]           col_r, col_nxt;
  logic [IMG_HEIGHT_W-1:0] row_r, row_nxt;
  logic [EW-1:0]           w_ext, w_eff, w_m1;
  logic [IMG_HEIGHT_W-1:0] h_eff, h_m1;
  logic                    last_col, last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RESET_WIDTH;
      image_height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[IMG_WIDTH_W-1:0];
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_wdata[IMG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate width to 3..MAX_WIDTH, height to at least 3
  always_comb begin
    w_ext = EW'(image_width_r);
    if (w_ext < EW'(3)) begin
      w_eff = EW'(3);
    end else if (w_ext > MAX_W_E) begin
      w_eff = MAX_W_E;
    end else begin
      w_eff = w_ext;
    end
    w_m1  = w_eff - EW'(1);
    h_eff = (image_height_r < IMG_HEIGHT_W'(3)) ? IMG_HEIGHT_W'(3) : image_height_r;
    h_m1  = h_eff - IMG_HEIGHT_W'(1);
  end

  assign last_col = EW'(col_r) >= w_m1;
  assign last_row = row_r >= h_m1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + IMG_HEIGHT_W'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col           = col_r;
  assign tag.emit      = (EW'(col_r) >= EW'(2)) && (row_r >= IMG_HEIGHT_W'(2));
  assign tag.row_end   = last_col;
  assign tag.frame_end = last_col && last_row;
endmodule

### design/bf3_window.sv
// Line store read-modify-write, 3x3 window columns and neighborhood sum.
`timescale 1ns / 1ps
module bf3_window import bf3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         acc,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  input  logic [PIXEL_W-1:0]           px,
  input  bf3_tag_t                     tag,
  output logic                         s2_valid,
  output logic [SUM_W-1:0]             s2_sum,
  output bf3_tag_t                     s2_tag
);
  localparam int CW = $clog2(MAX_WIDTH);

  logic               s1_valid_r;
  logic [PIXEL_W-1:0] s1_px_r;
  logic [CW-1:0]      s1_col_r;
  bf3_tag_t           s1_tag_r;
  logic [2*PIXEL_W-1:0] rd_data, wr_data;
  logic [PIXEL_W-1:0] top, mid;
  logic [PIXEL_W-1:0] win_r [6];
  logic [SUM_W-1:0]   sum;
  logic               s2_valid_r;
  logic [SUM_W-1:0]   s2_sum_r;
  bf3_tag_t           s2_tag_r;
  logic               step;

  // entry = {older row, newer row}; read at accept, written back from stage 1 when it advances.
  // Consecutive pixels never share a column, so no forwarding is needed.
  bf3_ram #(.W(2*PIXEL_W), .DEPTH(MAX_WIDTH)) u_line_store (
    .clk    (clk),
    .we     (step),
    .waddr  (s1_col_r),
    .wdata  (wr_data),
    .re     (en),
    .raddr  (col),
    .rdata_r(rd_data)
  );

  assign step    = s1_valid_r && en;
  assign top     = rd_data[2*PIXEL_W-1:PIXEL_W];
  assign mid     = rd_data[PIXEL_W-1:0];
  assign wr_data = {mid, s1_px_r};

  always_comb begin
    sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(s1_px_r);
    for (int i = 0; i < 6; i++) begin
      sum = sum + SUM_W'(win_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= acc;
      s2_valid_r <= s1_valid_r && s1_tag_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px_r  <= px;
      s1_col_r <= col;
      s1_tag_r <= tag;
      s2_sum_r <= sum;
      s2_tag_r <= s1_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (step) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_px_r;
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_sum   = s2_sum_r;
  assign s2_tag   = s2_tag_r;
endmodule

### design/bf3_div9.sv
// Divide-by-nine via reciprocal multiply and the output register.
`timescale 1ns / 1ps
module bf3_div9 import bf3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s2_valid,
  input  logic [SUM_W-1:0]  s2_sum,
  input  bf3_tag_t          s2_tag,
  output logic              en,
  bf3_mean_if.source        out_mean
);
  localparam int PROD_W = SUM_W + DIV9_MUL_W;

  logic               out_valid_r;
  logic [PIXEL_W-1:0] mean_r;
  logic               row_end_r, frame_end_r;
  logic [PROD_W-1:0]  prod;

  assign prod = PROD_W'(s2_sum) * PROD_W'(DIV9_MUL);
  assign en   = !out_valid_r || out_mean.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mean_r      <= prod[DIV9_SHIFT+PIXEL_W-1:DIV9_SHIFT];
      row_end_r   <= s2_tag.row_end;
      frame_end_r <= s2_tag.frame_end;
    end
  end

  assign out_mean.valid      = out_valid_r;
  assign out_mean.mean_value = mean_r;
  assign out_mean.row_end    = row_end_r;
  assign out_mean.frame_end  = frame_end_r;
endmodule

### design/box_filter_3x3_stream_top.sv
// 3x3 box mean over a raster pixel stream: each beat passes stage 1, stage 2 and the output register.
// Throughput 1 pixel per cycle while the sink takes results; the line store RAM is read at accept
// and written back from stage 1, each on its own port, so the pipeline never stalls on itself.
// Synchronous active-low reset clears counters, window and pipeline valids, and sets
// width 720, height 960. Line store RAM is not cleared; no clearing pass at start.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module box_filter_3x3_stream_top import bf3_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  bf3_pix_if.sink              in_pix,
  bf3_mean_if.source           out_mean,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);
  localparam int CW = $clog2(MAX_WIDTH);

  // Pipeline:
  //   accept : position counters give column and result tags, RAM read issued
  //   stage 1: line store data back, window shift, 9-pixel sum, RAM write-back
  //   stage 2: sum registered
  //   output : reciprocal multiply, result register (acts as the output buffer)
  // One global enable moves all stages; it is low only while a result beat is
  // held by the sink, so a new pixel beat is taken whenever the result slot
  // frees up in the same cycle.

  logic          en;
  logic          acc;
  logic [CW-1:0] col;
  bf3_tag_t      tag;
  logic          s2_valid;
  logic [SUM_W-1:0] s2_sum;
  bf3_tag_t      s2_tag;

  assign in_pix.ready = en;
  assign acc          = in_pix.valid && en;

  bf3_pos_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_pos_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .acc      (acc),
    .col      (col),
    .tag      (tag)
  );

  bf3_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .acc     (acc),
    .col     (col),
    .px      (in_pix.pixel),
    .tag     (tag),
    .s2_valid(s2_valid),
    .s2_sum  (s2_sum),
    .s2_tag  (s2_tag)
  );

  bf3_div9 u_div9 (
    .clk     (clk),
    .rst_n   (rst_n),
    .s2_valid(s2_valid),
    .s2_sum  (s2_sum),
    .s2_tag  (s2_tag),
    .en      (en),
    .out_mean(out_mean)
  );

  // Assertions
  `BF3_ASSERT_RST(a_rst_col, !rst_n |=> (col == '0), "column counter not cleared by reset")
  `BF3_ASSERT(a_out_rise, $rose(out_mean.valid) |-> $past(s2_valid), "result beat without sum")
  `BF3_ASSERT(a_s2_hold, (!en && s2_valid) |=> $stable(s2_sum), "stage 2 sum moved while stalled")
  `BF3_ASSERT(a_tag_frame, s2_valid && s2_tag.frame_end |-> s2_tag.row_end, "frame end off row end")
endmodule
